[sv/kse_pkg.sv]
package kse_pkg;

   localparam int unsigned MAX_DIGITS = 9;

   localparam logic [3:0]  COLS_NONE      = 4'hF;
   localparam logic [3:0]  ROWS_ALL_LOW   = 4'h0;
   localparam logic [15:0] DEBOUNCE_RESET = 16'd200;
   localparam logic [7:0]  KEY_NONE       = 8'h00;
   localparam logic [7:0]  KEY_DIGIT_LO   = 8'h30;
   localparam logic [7:0]  KEY_DIGIT_HI   = 8'h39;
   localparam logic [7:0]  KEY_BACK       = 8'h42;
   localparam logic [7:0]  KEY_ENTER      = 8'h44;
   localparam logic [31:0] RECIP_TEN      = 32'hCCCC_CCCD;
   localparam int unsigned RECIP_SHIFT    = 35;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SCAN,
      PH_RELEASE,
      PH_DEBOUNCE
   } phase_type;

   typedef struct packed {
      logic [29:0] value_next;
      logic [3:0]  count_next;
      logic        key_seen;
      logic [7:0]  key_char;
      logic        digit_echo;
      logic        erase_digit;
      logic [3:0]  cursor_position;
      logic        number_done;
      logic [29:0] number_value;
      logic [3:0]  digits_entered;
   } entry_type;

   function automatic logic [3:0] row_code(input logic [1:0] row);
      logic [3:0] code;
      unique case (row)
         2'd0: code = 4'hE;
         2'd1: code = 4'hD;
         2'd2: code = 4'hB;
         2'd3: code = 4'h7;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] key_of(input logic [1:0] row, input logic [1:0] col);
      logic [7:0] key;
      unique case ({row, col})
         4'h0: key = 8'h31;
         4'h1: key = 8'h32;
         4'h2: key = 8'h33;
         4'h3: key = 8'h41;
         4'h4: key = 8'h34;
         4'h5: key = 8'h35;
         4'h6: key = 8'h36;
         4'h7: key = 8'h42;
         4'h8: key = 8'h37;
         4'h9: key = 8'h38;
         4'hA: key = 8'h39;
         4'hB: key = 8'h43;
         4'hC: key = 8'h2A;
         4'hD: key = 8'h30;
         4'hE: key = 8'h23;
         4'hF: key = 8'h44;
      endcase
      return key;
   endfunction

endpackage

[sv/kse_entry.sv]
module kse_entry (
   input  logic [29:0]        entry_value,
   input  logic [3:0]         digit_count,
   input  logic [7:0]         held_key,
   input  logic               apply,
   output kse_pkg::entry_type entry
);

   logic [31:0] value_wide;
   logic [63:0] product;
   logic [29:0] value_div;
   logic [29:0] value_mul;
   logic        is_digit;

   assign value_wide = {2'b00, entry_value};
   assign product    = value_wide * kse_pkg::RECIP_TEN;
   assign value_div  = {1'b0, product[63:kse_pkg::RECIP_SHIFT]};
   assign value_mul  = {entry_value[26:0], 3'b000} + {entry_value[28:0], 1'b0}
                       + {26'd0, held_key[3:0]};
   assign is_digit   = (held_key >= kse_pkg::KEY_DIGIT_LO) && (held_key <= kse_pkg::KEY_DIGIT_HI);

   always_comb begin
      entry                 = '0;
      entry.value_next      = entry_value;
      entry.count_next      = digit_count;
      entry.key_char        = kse_pkg::KEY_NONE;
      entry.number_value    = entry_value;
      entry.digits_entered  = digit_count;
      if (apply) begin
         entry.key_seen = 1'b1;
         entry.key_char = held_key;
         if (is_digit) begin
            if (digit_count < 4'(kse_pkg::MAX_DIGITS)) begin
               entry.value_next      = value_mul;
               entry.count_next      = digit_count + 4'd1;
               entry.digit_echo      = 1'b1;
               entry.cursor_position = digit_count;
            end
         end else if (held_key == kse_pkg::KEY_BACK) begin
            if (digit_count != 4'd0) begin
               entry.value_next      = value_div;
               entry.count_next      = digit_count - 4'd1;
               entry.erase_digit     = 1'b1;
               entry.cursor_position = digit_count - 4'd1;
            end
         end else if (held_key == kse_pkg::KEY_ENTER) begin
            entry.value_next  = '0;
            entry.count_next  = '0;
            entry.number_done = 1'b1;
         end
         if (!entry.number_done) begin
            entry.number_value   = entry.value_next;
            entry.digits_entered = entry.count_next;
         end
      end
   end

endmodule

[sv/keypad_scan_number_entry.sv]
// Keypad scanner with decimal number entry, one column sample per transfer.
// Registered: each transfer goes into the input register, and the result register
// loads from it when the output is not stalled (input register, then result register).
// One transfer per cycle while the output is not stalled; an output stall holds the result register.
// Reset (synchronous, active high): idle, value and count cleared, debounce setting
// back to 200 ticks.
module keypad_scan_number_entry (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_column_levels,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_row_drive,
   output logic        rsp_key_seen,
   output logic [7:0]  rsp_key_char,
   output logic        rsp_digit_echo,
   output logic        rsp_erase_digit,
   output logic [3:0]  rsp_cursor_position,
   output logic        rsp_number_done,
   output logic [29:0] rsp_number_value,
   output logic [3:0]  rsp_digits_entered,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic                in_valid_ff, in_valid_in;
   logic [3:0]          in_cols_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         ticks_ff;
   kse_pkg::phase_type  phase_ff, phase_in;
   logic [1:0]          scan_row_ff, scan_row_in;
   logic [7:0]          held_key_ff, held_key_in;
   logic [15:0]         count_ff, count_in;
   logic [29:0]         value_ff;
   logic [3:0]          digits_ff;
   logic                apply;
   logic                col_found;
   logic [1:0]          col_index;
   logic [15:0]         count_dec;
   logic [3:0]          row_drive;
   logic                out_ready;
   logic                advance;
   logic                req_accept;
   kse_pkg::entry_type  entry;
   logic [3:0]          row_drive_ff;
   kse_pkg::entry_type  entry_ff;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && out_ready;
   assign req_stall  = in_valid_ff && !out_ready;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign count_dec    = (count_ff != 16'd0) ? count_ff - 16'd1 : 16'd0;

   always_comb begin
      col_found = 1'b1;
      col_index = 2'd0;
      unique case (in_cols_ff)
         4'hE:    col_index = 2'd0;
         4'hD:    col_index = 2'd1;
         4'hB:    col_index = 2'd2;
         4'h7:    col_index = 2'd3;
         default: col_found = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      phase_in    = phase_ff;
      scan_row_in = scan_row_ff;
      held_key_in = held_key_ff;
      count_in    = count_ff;
      apply       = 1'b0;
      unique case (phase_ff)
         kse_pkg::PH_IDLE: begin
            if (in_cols_ff != kse_pkg::COLS_NONE) begin
               phase_in    = kse_pkg::PH_SCAN;
               scan_row_in = 2'd0;
            end
         end
         kse_pkg::PH_SCAN: begin
            if (in_cols_ff != kse_pkg::COLS_NONE) begin
               scan_row_in = 2'd0;
               if (col_found) begin
                  held_key_in = kse_pkg::key_of(scan_row_ff, col_index);
                  phase_in    = kse_pkg::PH_RELEASE;
               end else begin
                  phase_in = kse_pkg::PH_IDLE;
               end
            end else if (scan_row_ff == 2'd3) begin
               scan_row_in = 2'd0;
               phase_in    = kse_pkg::PH_IDLE;
            end else begin
               scan_row_in = scan_row_ff + 2'd1;
            end
         end
         kse_pkg::PH_RELEASE: begin
            if (in_cols_ff == kse_pkg::COLS_NONE) begin
               if (ticks_ff == 16'd0) begin
                  phase_in = kse_pkg::PH_IDLE;
                  apply    = 1'b1;
               end else begin
                  count_in = ticks_ff;
                  phase_in = kse_pkg::PH_DEBOUNCE;
               end
            end
         end
         kse_pkg::PH_DEBOUNCE: begin
            count_in = count_dec;
            if (count_dec == 16'd0) begin
               phase_in = kse_pkg::PH_IDLE;
               apply    = 1'b1;
            end
         end
      endcase
   end

   // row drive output
   always_comb begin
      row_drive = kse_pkg::ROWS_ALL_LOW;
      unique case (phase_ff)
         kse_pkg::PH_IDLE: begin
            if (in_cols_ff != kse_pkg::COLS_NONE) begin
               row_drive = kse_pkg::row_code(2'd0);
            end
         end
         kse_pkg::PH_SCAN: begin
            if (in_cols_ff == kse_pkg::COLS_NONE && scan_row_ff != 2'd3) begin
               row_drive = kse_pkg::row_code(scan_row_ff + 2'd1);
            end
         end
         kse_pkg::PH_RELEASE:  row_drive = kse_pkg::ROWS_ALL_LOW;
         kse_pkg::PH_DEBOUNCE: row_drive = kse_pkg::ROWS_ALL_LOW;
      endcase
   end

   kse_entry u_entry (
      .entry_value (value_ff),
      .digit_count (digits_ff),
      .held_key    (held_key_ff),
      .apply       (apply),
      .entry       (entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ticks_ff     <= kse_pkg::DEBOUNCE_RESET;
         phase_ff     <= kse_pkg::PH_IDLE;
         scan_row_ff  <= 2'd0;
         held_key_ff  <= 8'd0;
         count_ff     <= 16'd0;
         value_ff     <= 30'd0;
         digits_ff    <= 4'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            ticks_ff <= csr_data;
         end
         if (advance) begin
            phase_ff    <= phase_in;
            scan_row_ff <= scan_row_in;
            held_key_ff <= held_key_in;
            count_ff    <= count_in;
            value_ff    <= entry.value_next;
            digits_ff   <= entry.count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_cols_ff <= req_column_levels;
      end
      if (advance) begin
         row_drive_ff <= row_drive;
         entry_ff     <= entry;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_row_drive       = row_drive_ff;
   assign rsp_key_seen        = entry_ff.key_seen;
   assign rsp_key_char        = entry_ff.key_char;
   assign rsp_digit_echo      = entry_ff.digit_echo;
   assign rsp_erase_digit     = entry_ff.erase_digit;
   assign rsp_cursor_position = entry_ff.cursor_position;
   assign rsp_number_done     = entry_ff.number_done;
   assign rsp_number_value    = entry_ff.number_value;
   assign rsp_digits_entered  = entry_ff.digits_entered;

endmodule

[sv/kse_checker.sv]
module kse_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_row_drive,
   input logic        rsp_key_seen,
   input logic [7:0]  rsp_key_char,
   input logic        rsp_digit_echo,
   input logic        rsp_erase_digit,
   input logic [3:0]  rsp_cursor_position,
   input logic        rsp_number_done,
   input logic [29:0] rsp_number_value,
   input logic [3:0]  rsp_digits_entered
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_number_value)
                                 && $stable(rsp_row_drive) && $stable(rsp_key_char))
      else $error("stalled result changed");

   // a key takes effect only with all rows low
   a_key_rows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_key_seen |-> rsp_row_drive == kse_pkg::ROWS_ALL_LOW)
      else $error("key effect while scanning");

   // echo only for digit keys, and never together with erase
   a_echo_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_digit_echo |-> rsp_key_seen && !rsp_erase_digit
         && rsp_key_char >= kse_pkg::KEY_DIGIT_LO && rsp_key_char <= kse_pkg::KEY_DIGIT_HI
         && rsp_digits_entered == rsp_cursor_position + 4'd1)
      else $error("bad digit echo");

   // finish only from the enter key
   a_done_enter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_number_done |-> rsp_key_seen && rsp_key_char == kse_pkg::KEY_ENTER)
      else $error("finish without enter key");

   a_digit_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_digits_entered <= 4'(kse_pkg::MAX_DIGITS))
      else $error("digit count over limit");

endmodule

bind keypad_scan_number_entry kse_checker u_kse_checker (.*);
